>>> hdl/sghb_pkg.sv
// ---------------------------------------------------------------------------
// sghb_pkg
// Shared types, constants and helpers for the spatial grid hash bucket block.
// ---------------------------------------------------------------------------
`default_nettype none

package sghb_pkg;

   localparam logic [31:0] HASH_K1 = 32'h8da6b343;
   localparam logic [31:0] HASH_K2 = 32'hd8163841;
   localparam logic [31:0] HASH_K3 = 32'hcb1ab31f;
   localparam logic [31:0] HASH_K4 = 32'h165667b1;

   localparam int SUM_W = 32;
   localparam int BKT_W = 31;

   localparam logic [1:0] CSR_BUCKET_COUNT = 2'd0;
   localparam logic [1:0] CSR_PLANAR_MODE  = 2'd1;

   // hash sum as sign and magnitude, ready for the remainder pipeline
   typedef struct packed {
      logic             neg;
      logic [SUM_W-1:0] mag;
   } hash_item_type;

   // one restoring remainder step: shift in one dividend bit, subtract if it fits
   function automatic logic [BKT_W-1:0] rem_step(input logic [BKT_W-1:0] r,
                                                 input logic             b,
                                                 input logic [BKT_W-1:0] m);
      logic [BKT_W:0] t;
      logic [BKT_W:0] d;
      t = {r, b};
      d = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
         rem_step = d[BKT_W-1:0];
      end else begin
         rem_step = t[BKT_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/sghb_front.sv
// ---------------------------------------------------------------------------
// sghb_front
// Accepts cells, forms the wrapped hash sum and splits it into sign and magnitude.
// ---------------------------------------------------------------------------
`default_nettype none

module sghb_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   planar_mode,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [31:0]     req_cell_x,
   input  wire logic signed [31:0]     req_cell_y,
   input  wire logic signed [31:0]     req_cell_z,
   input  wire logic [5:0]             req_grid_level,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output sghb_pkg::hash_item_type     out_item
);
   import sghb_pkg::*;

   logic              v1_ff, v1_in, v2_ff, v2_in, en;
   logic [SUM_W-1:0]  px_ff, py_ff, pz_ff, pl_ff;
   logic [SUM_W-1:0]  px_in, py_in, pz_in, pl_in, sum;
   hash_item_type     item_ff, item_in;

   assign en = !v2_ff || out_ready;
   assign req_ready = en;

   // low 32 bits of each product are the same for signed and unsigned operands
   assign px_in = HASH_K1 * $unsigned(req_cell_x);
   assign py_in = HASH_K2 * $unsigned(req_cell_y);
   assign pz_in = HASH_K3 * $unsigned(req_cell_z);
   assign pl_in = HASH_K4 * {26'd0, req_grid_level};
   assign v1_in = en ? req_valid : v1_ff;
   assign v2_in = en ? v1_ff : v2_ff;

   always_comb begin
      sum = px_ff + py_ff + pl_ff + (planar_mode ? '0 : pz_ff);
      item_in.neg = sum[SUM_W-1];
      item_in.mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         pl_ff   <= pl_in;
         item_ff <= item_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

>>> hdl/sghb_queue.sv
// ---------------------------------------------------------------------------
// sghb_queue
// Short queue that decouples the hash front from the remainder back end.
// ---------------------------------------------------------------------------
`default_nettype none

module sghb_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  sghb_pkg::hash_item_type  push_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output sghb_pkg::hash_item_type  pop_item
);
   import sghb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hash_item_type  mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           push, pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sghb_back.sv
// ---------------------------------------------------------------------------
// sghb_back
// Pipelined restoring remainder, one dividend bit per stage, then sign fix-up.
// ---------------------------------------------------------------------------
`default_nettype none

module sghb_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [30:0]         bucket_count,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  sghb_pkg::hash_item_type  in_item,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [30:0]              rsp_bucket_index
);
   import sghb_pkg::*;

   localparam int NST = SUM_W;

   logic              v_ff   [NST];
   logic              neg_ff [NST];
   logic [BKT_W-1:0]  r_ff   [NST];
   logic [SUM_W-1:0]  bits_ff[NST];
   logic              rv_ff;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic              en;

   assign en = !rv_ff || rsp_ready;
   assign in_ready = en;

   always_comb begin
      if (bucket_count == '0) begin
         bkt_in = '0;
      end else if (neg_ff[NST-1] && (r_ff[NST-1] != '0)) begin
         bkt_in = bucket_count - r_ff[NST-1];
      end else begin
         bkt_in = r_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            v_ff[i] <= 1'b0;
         end
         rv_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NST; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         rv_ff <= v_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0]  <= in_item.neg;
         r_ff[0]    <= rem_step('0, in_item.mag[SUM_W-1], bucket_count);
         bits_ff[0] <= {in_item.mag[SUM_W-2:0], 1'b0};
         for (int i = 1; i < NST; i++) begin
            neg_ff[i]  <= neg_ff[i-1];
            r_ff[i]    <= rem_step(r_ff[i-1], bits_ff[i-1][SUM_W-1], bucket_count);
            bits_ff[i] <= {bits_ff[i-1][SUM_W-2:0], 1'b0};
         end
         bkt_ff <= bkt_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_bucket_index = bkt_ff;

endmodule

`default_nettype wire

>>> hdl/spatial_grid_hash_bucket.sv
// ---------------------------------------------------------------------------
// spatial_grid_hash_bucket
// Hashes a signed grid cell and its level into a bucket below bucket_count, or 0 if it is 0.
// ---------------------------------------------------------------------------
//  channel | ports                                       | direction
//  req     | req_valid/ready, cell_x/y/z, grid_level     | in
//  rsp     | rsp_valid/ready, bucket_index               | out
//  csr     | csr_valid/ready, csr_index, csr_wdata       | in
//
//  One cell per clock sustained while rsp_ready stays high. From the accepting
//  edge the path runs through the products, which load at that edge, the sum
//  register, one entry in the queue, 32 remainder stages and the output register.
//  The 32-stage remainder pipeline sets the latency.
//  Synchronous reset clears all valids and loads bucket_count 10, planar off.
//  Front and back stall independently; the queue absorbs the difference.
// ---------------------------------------------------------------------------
`default_nettype none

module spatial_grid_hash_bucket #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_cell_x,
   input  wire logic signed [31:0] req_cell_y,
   input  wire logic signed [31:0] req_cell_z,
   input  wire logic [5:0]         req_grid_level,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [30:0]             rsp_bucket_index,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_wdata
);
   import sghb_pkg::*;

   logic [BKT_W-1:0] count_ff;
   logic             planar_ff;
   logic             f_valid, f_ready, b_valid, b_ready;
   hash_item_type    f_item, b_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= BKT_W'(10);
         planar_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_BUCKET_COUNT) begin
            count_ff <= csr_wdata;
         end else if (csr_index == CSR_PLANAR_MODE) begin
            planar_ff <= csr_wdata[0];
         end
      end
   end

   sghb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .planar_mode    (planar_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_z     (req_cell_z),
      .req_grid_level (req_grid_level),
      .out_valid      (f_valid),
      .out_ready      (f_ready),
      .out_item       (f_item)
   );

   sghb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_item   (b_item)
   );

   sghb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .bucket_count     (count_ff),
      .in_valid         (b_valid),
      .in_ready         (b_ready),
      .in_item          (b_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

`default_nettype wire

>>> bench/spatial_grid_hash_bucket_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spatial_grid_hash_bucket_check
// Watches the cell, bucket and register channels, computes the bucket of
// every accepted cell and compares it with the bucket that comes out.
// ---------------------------------------------------------------------------
`default_nettype none

module spatial_grid_hash_bucket_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [31:0] req_cell_x,
   input  wire logic signed [31:0] req_cell_y,
   input  wire logic signed [31:0] req_cell_z,
   input  wire logic [5:0]         req_grid_level,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [30:0]        rsp_bucket_index,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_wdata,
   output int                      fail_count,
   output int                      pending_buckets
);
   import sghb_pkg::*;

   logic [30:0] modulus;
   logic        planar;
   // ring of expected buckets, far deeper than the items the block can hold
   logic [30:0] want_mem[256];
   int          put_count;
   int          take_count;

   function automatic logic [30:0] cell_bucket(input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z, input logic [5:0] lvl,
                                               input logic [30:0] m, input logic flat);
      logic [31:0] s;
      logic [31:0] mag;
      logic [31:0] r;
      s = HASH_K1 * x + HASH_K2 * y + HASH_K4 * {26'd0, lvl};
      if (!flat) begin
         s = s + HASH_K3 * z;
      end
      if (m == 0) begin
         return '0;
      end
      mag = s[31] ? -s : s;
      r = mag % {1'b0, m};
      if (s[31] && r != 0) begin
         r = {1'b0, m} - r;
      end
      return r[30:0];
   endfunction

   assign pending_buckets = put_count - take_count;

   always @(posedge clock) begin
      logic [30:0] want;
      if (reset) begin
         modulus <= 31'd10;
         planar <= 1'b0;
         put_count <= 0;
         take_count <= 0;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BUCKET_COUNT) begin
               modulus <= csr_wdata;
            end else if (csr_index == CSR_PLANAR_MODE) begin
               planar <= csr_wdata[0];
            end
         end
         if (req_valid && req_ready) begin
            want_mem[put_count[7:0]] <= cell_bucket(req_cell_x, req_cell_y, req_cell_z,
                                                    req_grid_level, modulus, planar);
            put_count <= put_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (put_count == take_count) begin
               $error("bucket_index: none expected, actual %0d", rsp_bucket_index);
               fail_count <= fail_count + 1;
            end else begin
               want = want_mem[take_count[7:0]];
               take_count <= take_count + 1;
               if (want !== rsp_bucket_index) begin
                  $error("bucket_index: expected %0d, actual %0d", want, rsp_bucket_index);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> bench/spatial_grid_hash_bucket_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spatial_grid_hash_bucket_test
// Drives directed and random cells through several bucket counts and both
// grid modes, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module spatial_grid_hash_bucket_test;
   import sghb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_cell_x = '0;
   logic signed [31:0] req_cell_y = '0;
   logic signed [31:0] req_cell_z = '0;
   logic [5:0]         req_grid_level = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [30:0]        rsp_bucket_index;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [30:0]        csr_wdata = '0;
   int                 fail_count;
   int                 pending_buckets;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   int                 quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   spatial_grid_hash_bucket i_dut (.*);

   spatial_grid_hash_bucket_check i_check (.*);

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[spatial_grid_hash_bucket] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves req_valid high after the accept so the next item can follow at once
   task automatic send_cell(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [5:0] lvl);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cell_x <= x;
      req_cell_y <= y;
      req_cell_z <= z;
      req_grid_level <= lvl;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_buckets != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_cells(input int count);
      repeat (count) begin
         send_cell(random_coord(), random_coord(), random_coord(), 6'($urandom));
      end
   endtask

   initial begin
      logic [30:0] modulus_set[6];
      modulus_set = '{31'd1, 31'h7fff_ffff, 31'd7, 31'd1024, 31'd0, 31'd10};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes at reset settings
      send_cell(32'd0, 32'd0, 32'd0, 6'd0);
      send_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd63);
      send_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 6'd63);
      send_cell(32'hffff_ffff, 32'd0, 32'd0, 6'd0);
      send_cell(32'h8000_0000, 32'd0, 32'd0, 6'd0);
      send_cell(-10 * 32'h8da6_b343 + 32'h8da6_b343 - 32'h8da6_b343, 32'd0, 32'd0, 6'd0);
      send_cell(32'd0, 32'd0, 32'h1, 6'd1);
      // sum exactly most negative: x chosen so K1*x = 0x80000000 (x = 0x80000000)
      write_reg(CSR_PLANAR_MODE, 31'd1);
      send_cell(32'h8000_0000, 32'd0, 32'h1234_5678, 6'd0);
      send_cell(32'd0, 32'hffff_ffff, 32'h7fff_ffff, 6'd63);
      write_reg(CSR_BUCKET_COUNT, 31'd0);
      send_cell(32'h1234, 32'h5678, 32'h9abc, 6'd5);
      send_cell(32'h8000_0000, 32'h8000_0000, 32'd0, 6'd0);
      write_reg(CSR_BUCKET_COUNT, 31'd5);
      // sign cases: x = -5 gives a positive sum, x = 5 a negative one, neither a multiple of 5
      send_cell(32'hffff_fffb, 32'd0, 32'd0, 6'd0);
      send_cell(32'd5, 32'd0, 32'd0, 6'd0);
      // unused register index is ignored
      write_reg(2'd3, 31'd77);
      write_reg(2'd2, 31'd3);
      send_cell(32'hdead_beef, 32'h0bad_f00d, 32'h1, 6'd17);
      write_reg(CSR_PLANAR_MODE, 31'h7fff_fffe);
      send_cell(32'hdead_beef, 32'h0bad_f00d, 32'h1, 6'd17);

      // random phases over settings and idling mixes
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_BUCKET_COUNT, p == 5 ? 31'($urandom) : modulus_set[p]);
         write_reg(CSR_PLANAR_MODE, 31'(p & 1));
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
         random_cells(30);
         sender_idle_pct = 86;
         random_cells(20);
         sender_idle_pct = 0;
         receiver_stall_pct = 86;
         random_cells(20);
         sender_idle_pct = 37;
         receiver_stall_pct = 37;
         random_cells(20);
         // hold off until every bucket has arrived
         req_valid <= 1'b0;
         while (pending_buckets != 0) @(negedge clock);
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
      end

      drain();
      if (fail_count == 0) begin
         $display("[spatial_grid_hash_bucket] OK");
      end else begin
         $display("[spatial_grid_hash_bucket] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
